// File: rtl/gti_pkg.sv
// ----------------------------------------------------------------------------
// gti_pkg
// Shared constants for the grid trilinear interpolator: store geometry,
// register indexes, item modes and interpolation modes.
// ----------------------------------------------------------------------------
package gti_pkg;

    // Grid store geometry.
    localparam int unsigned STORE_DEPTH = 4096;
    localparam int unsigned STORE_AW    = 12;
    localparam int unsigned VAL_W       = 32;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z   = 3'd2;
    localparam logic [2:0] CFG_SCALE_X    = 3'd3;
    localparam logic [2:0] CFG_SCALE_Y    = 3'd4;
    localparam logic [2:0] CFG_SCALE_Z    = 3'd5;
    localparam logic [2:0] CFG_INTERP     = 3'd6;

    // Input item modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Interpolation modes.
    localparam logic INTERP_NEAREST = 1'b0;
    localparam logic INTERP_LINEAR  = 1'b1;

    // Reset value of the scale registers, 1.0 in Q16.16.
    localparam logic [31:0] SCALE_ONE = 32'h0001_0000;

endpackage

// File: rtl/gti_mul.sv
// ----------------------------------------------------------------------------
// gti_mul
// Shared signed 33 x 33 multiplier with a registered product. Serves both the
// coordinate mapping and every blend step.
// ----------------------------------------------------------------------------
module gti_mul (
    input  logic                i_clk,
    input  logic signed [32:0]  i_op_a,
    input  logic signed [32:0]  i_op_b,
    output logic signed [65:0]  o_prod
);

    logic signed [65:0] r_prod;

    // One product per cycle, registered.
    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;

endmodule

// File: rtl/gti_store.sv
// ----------------------------------------------------------------------------
// gti_store
// Grid value memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module gti_store (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [gti_pkg::STORE_AW-1:0]           i_waddr,
    input  logic [gti_pkg::VAL_W-1:0]              i_wdata,
    input  logic [gti_pkg::STORE_AW-1:0]           i_raddr,
    output logic [gti_pkg::VAL_W-1:0]              o_rdata
);

    logic [gti_pkg::VAL_W-1:0] r_mem [gti_pkg::STORE_DEPTH];
    logic [gti_pkg::VAL_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/grid_trilinear_interpolator.sv
// ----------------------------------------------------------------------------
// grid_trilinear_interpolator
// Samples a 3D grid of Q16.16 values, nearest entry or trilinear blend.
// ----------------------------------------------------------------------------
// A load item (tuser 0) with an address in the grid writes one grid entry in
// the cycle it is accepted and the block stays ready. A query item (tuser 1)
// runs through one shared multiplier under a sequencer: a map and a post state
// per axis to map the coordinate, then a read and a wait state per grid read
// from the single memory read port, and in linear mode a multiply and an
// accumulate state per blend, before its result reaches the output register;
// the input is not ready while a query is in progress.
module grid_trilinear_interpolator #(
    parameter int DIM_X = 16,
    parameter int DIM_Y = 16,
    parameter int DIM_Z = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input stream.
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata from bit 0: entry_address[11:0], entry_value[31:0], coord_x[31:0],
    // coord_y[31:0], coord_z[31:0], four zero bits.
    input  logic [143:0]  s_axis_tdata,
    // tuser: mode.
    input  logic          s_axis_tuser,
    // Output stream.
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: sample_value[31:0].
    output logic [31:0]   m_axis_tdata,
    // Configuration writes.
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    localparam int XW    = $clog2(DIM_X);
    localparam int YW    = $clog2(DIM_Y);
    localparam int ZW    = $clog2(DIM_Z);
    localparam int TOTAL = DIM_X * DIM_Y * DIM_Z;
    localparam int AW    = $clog2(TOTAL + 1);
    localparam int YZ    = DIM_Y * DIM_Z;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [1:0] LV_X = 2'd0;
    localparam logic [1:0] LV_Y = 2'd1;
    localparam logic [1:0] LV_Z = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_MAP, S_POST, S_RD, S_WT, S_MUL, S_ACC, S_OUT
    } t_state;

    t_state r_state;

    logic [31:0] r_ox, r_oy, r_oz, r_sx, r_sy, r_sz;
    logic        r_interp;
    logic [31:0] r_cx, r_cy, r_cz;
    logic        r_lin;
    logic [1:0]  r_ax;
    logic        r_dpos;
    logic [XW-1:0] r_xlo, r_xhi, r_xn;
    logic [YW-1:0] r_ylo, r_yhi, r_yn;
    logic [ZW-1:0] r_zlo, r_zhi, r_zn;
    logic [15:0] r_wx, r_wy, r_wz;
    logic [2:0]  r_c;
    logic [1:0]  r_lvl;
    logic        r_oob;
    logic [31:0] r_a, r_b, r_t0, r_t1, r_res;
    logic        r_mvalid;
    logic [31:0] r_mdata;

    logic               in_acc;
    logic               load_we;
    logic [31:0]        coord, origin, scale, last;
    logic signed [32:0] d;
    logic               dpos;
    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod;
    logic [63:0]        p;
    logic [31:0]        ip, lo, hi, near;
    logic [32:0]        nr;
    logic               at_end;
    logic [15:0]        w_post, w_sel;
    logic [XW-1:0]      ci;
    logic [YW-1:0]      cj;
    logic [ZW-1:0]      ck;
    logic [AW-1:0]      full_addr;
    logic [31:0]        rdata, rval;
    logic signed [32:0] diff;
    logic signed [65:0] rnd;
    logic signed [65:0] shf;
    logic [33:0]        res34;
    logic [31:0]        res;
    logic               out_free;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign out_free      = !r_mvalid || m_axis_tready;

    // Loads go straight to the store when the address lies inside the grid.
    assign load_we = in_acc && (s_axis_tuser == gti_pkg::MODE_LOAD)
                     && (32'(s_axis_tdata[11:0]) < 32'(TOTAL));

    // Per axis operand selection for the mapping multiply.
    always_comb begin
        unique case (r_ax)
            AX_X: begin
                coord = r_cx; origin = r_ox; scale = r_sx; last = 32'(DIM_X - 1);
            end
            AX_Y: begin
                coord = r_cy; origin = r_oy; scale = r_sy; last = 32'(DIM_Y - 1);
            end
            default: begin
                coord = r_cz; origin = r_oz; scale = r_sz; last = 32'(DIM_Z - 1);
            end
        endcase
    end

    assign d    = $signed({coord[31], coord}) - $signed({origin[31], origin});
    assign dpos = !d[32] && (d != 33'sd0);

    // Blend weight by level.
    always_comb begin
        unique case (r_lvl)
            LV_X:    w_sel = r_wx;
            LV_Y:    w_sel = r_wy;
            default: w_sel = r_wz;
        endcase
    end

    assign diff = $signed({r_b[31], r_b}) - $signed({r_a[31], r_a});

    // Shared multiplier operands.
    always_comb begin
        if (r_state == S_MAP) begin
            op_a = d;
            op_b = $signed({1'b0, scale});
        end else begin
            op_a = diff;
            op_b = $signed({17'd0, w_sel});
        end
    end

    gti_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_prod (prod)
    );

    // Cell index, weight and nearest index from the mapped position.
    assign p      = prod[63:0];
    assign ip     = p[63:32];
    assign at_end = (ip >= last);
    assign nr     = {1'b0, ip} + 33'(p[31]);
    always_comb begin
        if (!r_dpos) begin
            lo = '0; hi = '0; w_post = '0; near = '0;
        end else begin
            lo     = at_end ? last : ip;
            hi     = at_end ? last : ip + 32'd1;
            w_post = at_end ? 16'd0 : p[31:16];
            near   = (nr > {1'b0, last}) ? last : nr[31:0];
        end
    end

    // Corner selection and flattened address.
    always_comb begin
        if (!r_lin) begin
            ci = r_xn; cj = r_yn; ck = r_zn;
        end else begin
            ci = r_c[0] ? r_xhi : r_xlo;
            cj = r_c[1] ? r_yhi : r_ylo;
            ck = r_c[2] ? r_zhi : r_zlo;
        end
    end
    assign full_addr = AW'(ci) * AW'(YZ) + AW'(cj) * AW'(DIM_Z) + AW'(ck);

    gti_store u_store (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (s_axis_tdata[11:0]),
        .i_wdata (s_axis_tdata[43:12]),
        .i_raddr (gti_pkg::STORE_AW'(full_addr)),
        .o_rdata (rdata)
    );

    // Addresses past the store read as zero.
    assign rval = r_oob ? 32'd0 : rdata;

    // Blend: a + floor(((b - a) * w + 32768) / 65536).
    assign rnd   = prod + 66'sd32768;
    assign shf   = rnd >>> 16;
    assign res34 = {{2{r_a[31]}}, r_a} + 34'(shf);
    assign res   = res34[31:0];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0; r_oy <= '0; r_oz <= '0;
            r_sx <= gti_pkg::SCALE_ONE;
            r_sy <= gti_pkg::SCALE_ONE;
            r_sz <= gti_pkg::SCALE_ONE;
            r_interp <= gti_pkg::INTERP_NEAREST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gti_pkg::CFG_ORIGIN_X: r_ox <= i_cfg_data;
                gti_pkg::CFG_ORIGIN_Y: r_oy <= i_cfg_data;
                gti_pkg::CFG_ORIGIN_Z: r_oz <= i_cfg_data;
                gti_pkg::CFG_SCALE_X:  r_sx <= i_cfg_data;
                gti_pkg::CFG_SCALE_Y:  r_sy <= i_cfg_data;
                gti_pkg::CFG_SCALE_Z:  r_sz <= i_cfg_data;
                gti_pkg::CFG_INTERP:   r_interp <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mvalid <= 1'b0;
            r_ax     <= AX_X;
            r_c      <= '0;
            r_lvl    <= LV_X;
        end else begin
            // The output register fills from S_OUT and empties on a transfer.
            if (r_state == S_OUT && out_free) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && s_axis_tuser == gti_pkg::MODE_QUERY) begin
                        r_cx    <= s_axis_tdata[75:44];
                        r_cy    <= s_axis_tdata[107:76];
                        r_cz    <= s_axis_tdata[139:108];
                        r_lin   <= (r_interp == gti_pkg::INTERP_LINEAR);
                        r_ax    <= AX_X;
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    r_dpos  <= dpos;
                    r_state <= S_POST;
                end
                S_POST: begin
                    unique case (r_ax)
                        AX_X: begin
                            r_xlo <= XW'(lo); r_xhi <= XW'(hi); r_xn <= XW'(near);
                            r_wx  <= w_post;
                        end
                        AX_Y: begin
                            r_ylo <= YW'(lo); r_yhi <= YW'(hi); r_yn <= YW'(near);
                            r_wy  <= w_post;
                        end
                        default: begin
                            r_zlo <= ZW'(lo); r_zhi <= ZW'(hi); r_zn <= ZW'(near);
                            r_wz  <= w_post;
                        end
                    endcase
                    if (r_ax == AX_Z) begin
                        r_c     <= '0;
                        r_lvl   <= LV_X;
                        r_state <= S_RD;
                    end else begin
                        r_ax    <= r_ax + 2'd1;
                        r_state <= S_MAP;
                    end
                end
                S_RD: begin
                    r_oob   <= (32'(full_addr) >= gti_pkg::STORE_DEPTH);
                    r_state <= S_WT;
                end
                S_WT: begin
                    if (!r_lin) begin
                        r_res   <= rval;
                        r_state <= S_OUT;
                    end else if (!r_c[0]) begin
                        r_a     <= rval;
                        r_c     <= r_c + 3'd1;
                        r_state <= S_RD;
                    end else begin
                        r_b     <= rval;
                        r_lvl   <= LV_X;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    priority if (r_lvl == LV_Z) begin
                        r_res   <= res;
                        r_state <= S_OUT;
                    end else if (r_lvl == LV_Y) begin
                        if (!r_c[2]) begin
                            r_t1    <= res;
                            r_c     <= r_c + 3'd1;
                            r_state <= S_RD;
                        end else begin
                            r_a     <= r_t1;
                            r_b     <= res;
                            r_lvl   <= LV_Z;
                            r_state <= S_MUL;
                        end
                    end else begin
                        // A finished x blend: first of a y pair waits, second pairs up.
                        if (!r_c[1]) begin
                            r_t0    <= res;
                            r_c     <= r_c + 3'd1;
                            r_state <= S_RD;
                        end else begin
                            r_a     <= r_t0;
                            r_b     <= res;
                            r_lvl   <= LV_Y;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_mdata  <= r_res;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
